// ===== src/spectrum_bin_magnitude_phase_assert.svh =====
// ----------------------------------------------------------------------------
// spectrum bin magnitude and phase: assertion macros
// clocked checks on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BIN_MAGNITUDE_PHASE_ASSERT_SVH
`define SPECTRUM_BIN_MAGNITUDE_PHASE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SBMP_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SBMP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define SBMP_ASSERT(lbl, expr, msg)
`define SBMP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/sbmp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbmp_pkg
// shared types, constants and the arctangent table
// ----------------------------------------------------------------------------
package sbmp_pkg;

	localparam int unsigned TRANSFORM_LENGTH_DEF = 65536;
	localparam int unsigned ATAN_STEPS = 20;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned CORDIC_W = 35;
	localparam int unsigned ANGLE_W = 26;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_AMP_CUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AMP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_NORM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP = 3'd4;

	localparam logic [31:0] INV_NORM_RST  = 32'hFFFF_FFFF;
	localparam logic [15:0] MAX_BIN_RST   = 16'd32768;
	localparam logic [31:0] FREQ_STEP_RST = 32'd65536;

	localparam logic [15:0] PH_ZERO    = 16'd0;
	localparam logic [15:0] PH_QUARTER = 16'd16384;
	localparam logic [15:0] PH_HALF    = 16'd32768;
	localparam logic [15:0] PH_3QUART  = 16'd49152;
	localparam logic signed [ANGLE_W-1:0] ANGLE_HALF = 26'sd8388608;

	typedef struct packed {
		logic [15:0]        bin_index;
		logic signed [31:0] real_part;
		logic signed [31:0] imag_part;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_bin;
		logic [47:0] frequency;
		logic [31:0] amplitude;
		logic [15:0] phase;
	} out_item_t;

	// atan(2^-i) in units of 2^-24 turn
	function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [4:0] i);
		logic signed [ANGLE_W-1:0] a;
		case (i)
			5'd0:    a = 26'sd2097152;
			5'd1:    a = 26'sd1238021;
			5'd2:    a = 26'sd654136;
			5'd3:    a = 26'sd332050;
			5'd4:    a = 26'sd166669;
			5'd5:    a = 26'sd83416;
			5'd6:    a = 26'sd41718;
			5'd7:    a = 26'sd20860;
			5'd8:    a = 26'sd10430;
			5'd9:    a = 26'sd5215;
			5'd10:   a = 26'sd2608;
			5'd11:   a = 26'sd1304;
			5'd12:   a = 26'sd652;
			5'd13:   a = 26'sd326;
			5'd14:   a = 26'sd163;
			5'd15:   a = 26'sd81;
			5'd16:   a = 26'sd41;
			5'd17:   a = 26'sd20;
			5'd18:   a = 26'sd10;
			5'd19:   a = 26'sd5;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/sbmp_isqrt.sv =====
// ----------------------------------------------------------------------------
// sbmp_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module sbmp_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	localparam int unsigned N = sbmp_pkg::SQRT_STEPS;

	logic [63:0] rem_s  [0:N];
	logic [63:0] root_s [0:N];

	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (2 * (N - 1 - k));
		logic [63:0] trial;
		assign trial = root_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign root = root_s[N][31:0];

endmodule

// ===== src/sbmp_cordic.sv =====
// ----------------------------------------------------------------------------
// sbmp_cordic
// pipelined vectoring cordic, one rotation per stage
// ----------------------------------------------------------------------------
module sbmp_cordic (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic signed [sbmp_pkg::CORDIC_W-1:0]        x_in,
	input  logic signed [sbmp_pkg::CORDIC_W-1:0]        y_in,
	input  logic signed [sbmp_pkg::ANGLE_W-1:0]         z_in,
	output logic [23:0]                                 angle
);

	localparam int unsigned N = sbmp_pkg::ATAN_STEPS;
	localparam int unsigned W = sbmp_pkg::CORDIC_W;

	logic signed [W-1:0]                     x_s [0:N];
	logic signed [W-1:0]                     y_s [0:N];
	logic signed [sbmp_pkg::ANGLE_W-1:0]     z_s [0:N];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic              y_pos;
		logic signed [W-1:0] xs;
		logic signed [W-1:0] ys;
		assign y_pos = !y_s[i][W-1] && (y_s[i] != '0);
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_pos) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + sbmp_pkg::atan_step(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - sbmp_pkg::atan_step(5'(i));
				end
			end
		end
	end

	assign angle = z_s[N][23:0];

endmodule

// ===== src/spectrum_bin_magnitude_phase.sv =====
// ----------------------------------------------------------------------------
// spectrum_bin_magnitude_phase
// amplitude, phase and frequency of one dft bin per item
// ----------------------------------------------------------------------------
// usage
//   in channel: one bin per item (index, signed real and imaginary parts),
//   taken on in_valid high and in_stall low
//   out channel: zero or one result per item (bin, frequency, amplitude,
//   phase), taken on out_valid high and out_stall low
//   cfg port: plain write, cfg_we with cfg_index and cfg_data; write only
//   while the pipeline is empty
// latency and throughput
//   37 register stages: out_valid rises 36 cycles after the accepting edge;
//   one item per cycle sustained
//   the 32-stage square root sets the depth, the 20-stage cordic runs
//   beside it and its angle is delayed to meet the root
// stall
//   the whole pipeline freezes while a result waits under out_stall, so
//   in_stall follows out_valid and out_stall; nothing is lost or repeated
//   dropped bins leave a bubble and give no result
// reset
//   empties the pipeline and loads register defaults (full-scale
//   inv_norm, max_bin 32768, unit freq_step)
// ----------------------------------------------------------------------------
`include "spectrum_bin_magnitude_phase_assert.svh"

module spectrum_bin_magnitude_phase #(
	parameter int unsigned TRANSFORM_LENGTH = sbmp_pkg::TRANSFORM_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sbmp_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sbmp_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [sbmp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam logic [16:0] LEN = 17'(TRANSFORM_LENGTH);
	localparam int unsigned LAST = 35;   // stage where root and angle meet

	typedef struct packed {
		logic [15:0] bin;
		logic [47:0] freq;
		logic        dc;
		logic        spec;
		logic [15:0] spec_ph;
	} side_t;

	// configuration registers
	logic [31:0] amp_cut_q, min_amp_q, inv_norm_q, freq_step_q;
	logic [15:0] max_bin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_cut_q   <= '0;
			min_amp_q   <= '0;
			inv_norm_q  <= sbmp_pkg::INV_NORM_RST;
			max_bin_q   <= sbmp_pkg::MAX_BIN_RST;
			freq_step_q <= sbmp_pkg::FREQ_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbmp_pkg::REG_AMP_CUT:   amp_cut_q   <= cfg_data;
				sbmp_pkg::REG_MIN_AMP:   min_amp_q   <= cfg_data;
				sbmp_pkg::REG_INV_NORM:  inv_norm_q  <= cfg_data;
				sbmp_pkg::REG_MAX_BIN:   max_bin_q   <= cfg_data[15:0];
				sbmp_pkg::REG_FREQ_STEP: freq_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the pipeline moves unless a result is held back
	logic adv;
	logic out_valid_q;
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// entry decode
	logic [15:0]        bin;
	logic signed [31:0] re, im;
	logic               idx_bad, zero_im, spec;
	logic [15:0]        spec_ph;
	logic [31:0]        ar, ai;
	logic signed [sbmp_pkg::CORDIC_W-1:0] cx, cy;
	logic signed [sbmp_pkg::ANGLE_W-1:0]  cz;

	always_comb begin
		bin     = in_data.bin_index;
		re      = in_data.real_part;
		idx_bad = (bin > max_bin_q) || ({1'b0, bin} >= LEN);
		// dc and nyquist bins are real
		zero_im = (bin == '0) || ({bin, 1'b0} == LEN);
		im      = zero_im ? 32'sd0 : in_data.imag_part;
		ar      = re[31] ? (~32'(re) + 32'd1) : 32'(re);
		ai      = im[31] ? (~32'(im) + 32'd1) : 32'(im);
		// on-axis and zero vectors bypass the cordic
		spec    = 1'b0;
		spec_ph = sbmp_pkg::PH_ZERO;
		if (im == 32'sd0) begin
			spec    = 1'b1;
			spec_ph = re[31] ? sbmp_pkg::PH_HALF : sbmp_pkg::PH_ZERO;
		end else if (re == 32'sd0) begin
			spec    = 1'b1;
			spec_ph = im[31] ? sbmp_pkg::PH_3QUART : sbmp_pkg::PH_QUARTER;
		end
		// left half plane: mirror and start from half a turn
		if (re[31]) begin
			cx = -sbmp_pkg::CORDIC_W'(re);
			cy = -sbmp_pkg::CORDIC_W'(im);
			cz = sbmp_pkg::ANGLE_HALF;
		end else begin
			cx = sbmp_pkg::CORDIC_W'(re);
			cy = sbmp_pkg::CORDIC_W'(im);
			cz = '0;
		end
	end

	// valid bits, one per stage
	logic v_s [1:LAST+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST + 1; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= in_valid && !idx_bad;
			for (int k = 2; k <= LAST + 1; k++) v_s[k] <= v_s[k-1];
		end
	end

	// stage 1
	logic [31:0] ar_s1, ai_s1;
	logic signed [sbmp_pkg::CORDIC_W-1:0] cx_s1, cy_s1;
	logic signed [sbmp_pkg::ANGLE_W-1:0]  cz_s1;
	side_t side_s [1:LAST];

	always_ff @(posedge clk) begin
		if (adv) begin
			ar_s1           <= ar;
			ai_s1           <= ai;
			cx_s1           <= cx;
			cy_s1           <= cy;
			cz_s1           <= cz;
			side_s[1].bin     <= bin;
			side_s[1].freq    <= '0;
			side_s[1].dc      <= (bin == '0);
			side_s[1].spec    <= spec;
			side_s[1].spec_ph <= spec_ph;
		end
	end

	// stage 2: squares and frequency
	logic [63:0] sqr_s2, sqi_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqr_s2 <= 64'(ar_s1) * 64'(ar_s1);
			sqi_s2 <= 64'(ai_s1) * 64'(ai_s1);
			side_s[2].bin     <= side_s[1].bin;
			side_s[2].freq    <= 48'(side_s[1].bin) * 48'(freq_step_q);
			side_s[2].dc      <= side_s[1].dc;
			side_s[2].spec    <= side_s[1].spec;
			side_s[2].spec_ph <= side_s[1].spec_ph;
		end
	end

	// stage 3: sum of squares
	logic [63:0] sum_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sqr_s2 + sqi_s2;
		end
	end

	// side band follows the root
	for (genvar k = 3; k <= LAST; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// stages 4 to 35: magnitude
	logic [31:0] mag;

	sbmp_isqrt u_isqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (sum_s3),
		.root     (mag)
	);

	// stages 2 to 21: angle
	logic [23:0] angle;
	logic [24:0] angle_rnd;

	sbmp_cordic u_cordic (
		.clk   (clk),
		.en    (adv),
		.x_in  (cx_s1),
		.y_in  (cy_s1),
		.z_in  (cz_s1),
		.angle (angle)
	);

	assign angle_rnd = {1'b0, angle} + 25'd128;

	// delay the rounded angle to meet the root
	logic [15:0] ph_s [22:LAST];

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s[22] <= angle_rnd[23:8];
			for (int k = 23; k <= LAST; k++) ph_s[k] <= ph_s[k-1];
		end
	end

	// stage 36: scale by the reciprocal norm
	logic [63:0] prod_s36;
	side_t       side_s36;
	logic [15:0] ph_s36;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s36 <= 64'(mag) * 64'(inv_norm_q);
			side_s36 <= side_s[LAST];
			ph_s36   <= ph_s[LAST];
		end
	end

	// stage 37: saturate, pick phase, apply the cut
	logic [31:0] amp;
	logic [15:0] ph;

	always_comb begin
		if (side_s36.dc) begin
			amp = prod_s36[63:32];
		end else begin
			amp = prod_s36[63] ? 32'hFFFF_FFFF : prod_s36[62:31];
		end
		if (side_s36.dc || (amp < min_amp_q)) begin
			ph = sbmp_pkg::PH_ZERO;
		end else if (side_s36.spec) begin
			ph = side_s36.spec_ph;
		end else begin
			ph = ph_s36;
		end
	end

	sbmp_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s[LAST+1] && !(amp < amp_cut_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_bin   <= side_s36.bin;
			out_q.frequency <= side_s36.freq;
			out_q.amplitude <= amp;
			out_q.phase     <= ph;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SBMP_ASSERT(a_amp_over_cut, !out_valid || (out_data.amplitude >= amp_cut_q), "amplitude below cut emitted")
	`SBMP_ASSERT(a_bin_in_range, !out_valid || (out_data.out_bin <= max_bin_q), "bin above max emitted")
	`SBMP_ASSERT(a_dc_phase, !(out_valid && out_data.out_bin == '0) || (out_data.phase == '0), "dc bin with phase")
	`SBMP_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(prod_s36) && $stable(v_s[LAST+1]), "pipeline moved under stall")

endmodule
